### design/prr_pkg.sv
package prr_pkg;

	// Protocol bytes
	localparam logic [7:0] BYTE_PRE  = 8'hFF;
	localparam logic [7:0] BYTE_STX  = 8'h02;
	localparam logic [7:0] BYTE_ETX  = 8'h03;
	localparam logic [7:0] BYTE_ESC  = 8'h10;
	localparam logic [7:0] BYTE_POLL = 8'h50;
	localparam logic [7:0] BYTE_GET  = 8'h52;
	localparam logic [7:0] ADDR_BASE = 8'd65;

	// Position of the last byte of the request frame
	localparam logic [2:0] TX_LAST_POS = 3'd5;

	// Configuration register indexes
	localparam logic CFG_NODE_NUMBER = 1'b0;
	localparam logic CFG_BYTE_COUNT  = 1'b1;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_CHANGE = 2'd1,
		KIND_DONE   = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_READ    = 3'd1,
		ERR_NO_STX  = 3'd2,
		ERR_ADDRESS = 3'd3,
		ERR_COMMAND = 3'd4,
		ERR_LENGTH  = 3'd5
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRE,
		ST_ADDR,
		ST_CMD,
		ST_DATA,
		ST_TX,
		ST_ERR,
		ST_SCAN,
		ST_FINAL
	} state_t;

	typedef enum logic [2:0] {
		OSEL_TX,
		OSEL_ERR,
		OSEL_PEND,
		OSEL_PEND_LAST,
		OSEL_DONE
	} osel_t;

	// Controller to datapath
	typedef struct packed {
		logic  poll_start;
		logic  esc_set;
		logic  esc_clr;
		logic  store;
		logic  err_set;
		err_t  err_code;
		logic  tx_adv;
		logic  scan_start;
		logic  scan_adv;
		logic  pend_take;
		logic  out_load;
		osel_t out_sel;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic op;
		logic rx_err;
		logic is_pre;
		logic is_stx;
		logic is_addr;
		logic is_get;
		logic is_esc;
		logic is_etx;
		logic esc;
		logic len_ok;
		logic tx_end;
		logic scan_end;
		logic diff;
		logic pend_valid;
		logic out_free;
	} sts_t;

	// Request frame: FF FF STX addr 'P' ETX
	function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic [7:0] addr);
		logic [7:0] b;
		case (pos)
			3'd0:    b = BYTE_PRE;
			3'd1:    b = BYTE_PRE;
			3'd2:    b = BYTE_STX;
			3'd3:    b = addr;
			3'd4:    b = BYTE_POLL;
			default: b = BYTE_ETX;
		endcase
		return b;
	endfunction

endpackage

### design/poll_response_receiver_core.sv
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata rx_byte, tuser op + rx_error
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata tx/bit/error fields, tuser kind
// cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// A received byte is taken whenever the parser waits for input.
// A poll request sends six frame bytes, one per cycle the output is free.
// A good frame scans its stored bits one per cycle unless the sink stalls a
// change result, then ends the scan and sends the final result.
// Input stalls while frame bytes, errors or scan results are being sent.
// arst_n clears the parser, output valid and stored inputs at once.
module poll_response_receiver_core #(
	parameter int MAX_INPUT_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_axis_tuser,   // [0] op, [1] rx_error
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] tx_byte, [13:8] bit_index, [14] bit_value,
	                                    // [17:15] error_code, [23:18] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	prr_pkg::cmd_t cmd;
	prr_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	// Parse and sequence control
	prr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	// Buffers, counters and output register
	prr_datapath #(
		.MAX_INPUT_BYTES (MAX_INPUT_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_axis_tdata),
		.s_tuser   (s_axis_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_axis_tready),
		.m_tvalid  (m_axis_tvalid),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser),
		.m_tlast   (m_axis_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### design/prr_ctrl.sv
module prr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  prr_pkg::sts_t  sts,
	output logic           in_ready,
	output prr_pkg::cmd_t  cmd
);

	prr_pkg::state_t state_q;
	prr_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			prr_pkg::ST_IDLE, prr_pkg::ST_PRE, prr_pkg::ST_ADDR,
			prr_pkg::ST_CMD, prr_pkg::ST_DATA: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!sts.op) begin
						// start a poll from any parse phase
						cmd.poll_start = 1'b1;
						state_d        = prr_pkg::ST_TX;
					end else if (state_q == prr_pkg::ST_IDLE) begin
						// drop bytes while not armed
						state_d = prr_pkg::ST_IDLE;
					end else if (sts.rx_err) begin
						cmd.err_set  = 1'b1;
						cmd.err_code = prr_pkg::ERR_READ;
						cmd.esc_clr  = 1'b1;
						state_d      = prr_pkg::ST_ERR;
					end else begin
						case (state_q)
							prr_pkg::ST_PRE: begin
								if (sts.is_pre) begin
									state_d = prr_pkg::ST_PRE;
								end else if (sts.is_stx) begin
									state_d = prr_pkg::ST_ADDR;
								end else begin
									cmd.err_set  = 1'b1;
									cmd.err_code = prr_pkg::ERR_NO_STX;
									state_d      = prr_pkg::ST_ERR;
								end
							end
							prr_pkg::ST_ADDR: begin
								if (sts.is_addr) begin
									state_d = prr_pkg::ST_CMD;
								end else begin
									cmd.err_set  = 1'b1;
									cmd.err_code = prr_pkg::ERR_ADDRESS;
									state_d      = prr_pkg::ST_ERR;
								end
							end
							prr_pkg::ST_CMD: begin
								if (sts.is_get) begin
									state_d = prr_pkg::ST_DATA;
								end else begin
									cmd.err_set  = 1'b1;
									cmd.err_code = prr_pkg::ERR_COMMAND;
									state_d      = prr_pkg::ST_ERR;
								end
							end
							default: begin
								if (sts.esc) begin
									// escaped byte is literal
									cmd.esc_clr = 1'b1;
									cmd.store   = 1'b1;
								end else if (sts.is_esc) begin
									cmd.esc_set = 1'b1;
								end else if (sts.is_etx) begin
									if (sts.len_ok) begin
										cmd.scan_start = 1'b1;
										state_d        = prr_pkg::ST_SCAN;
									end else begin
										cmd.err_set  = 1'b1;
										cmd.err_code = prr_pkg::ERR_LENGTH;
										state_d      = prr_pkg::ST_ERR;
									end
								end else begin
									cmd.store = 1'b1;
								end
							end
						endcase
					end
				end
			end
			prr_pkg::ST_TX: begin
				// send the request frame one byte per free output slot
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = prr_pkg::OSEL_TX;
					cmd.tx_adv   = 1'b1;
					if (sts.tx_end) begin
						state_d = prr_pkg::ST_PRE;
					end
				end
			end
			prr_pkg::ST_ERR: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = prr_pkg::OSEL_ERR;
					state_d      = prr_pkg::ST_IDLE;
				end
			end
			prr_pkg::ST_SCAN: begin
				// hold one found change back so the final one can carry last
				if (sts.scan_end) begin
					state_d = prr_pkg::ST_FINAL;
				end else if (sts.diff && sts.pend_valid) begin
					if (sts.out_free) begin
						cmd.out_load  = 1'b1;
						cmd.out_sel   = prr_pkg::OSEL_PEND;
						cmd.pend_take = 1'b1;
						cmd.scan_adv  = 1'b1;
					end
				end else if (sts.diff) begin
					cmd.pend_take = 1'b1;
					cmd.scan_adv  = 1'b1;
				end else begin
					cmd.scan_adv = 1'b1;
				end
			end
			prr_pkg::ST_FINAL: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = sts.pend_valid ? prr_pkg::OSEL_PEND_LAST
					                              : prr_pkg::OSEL_DONE;
					state_d      = prr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### design/prr_datapath.sv
module prr_datapath #(
	parameter int MAX_INPUT_BYTES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     s_tdata,
	input  logic [1:0]     s_tuser,
	input  logic           cfg_valid,
	input  logic           cfg_index,
	input  logic [6:0]     cfg_data,
	input  logic           m_tready,
	output logic           m_tvalid,
	output logic [23:0]    m_tdata,
	output logic [1:0]     m_tuser,
	output logic           m_tlast,
	input  prr_pkg::cmd_t  cmd,
	output prr_pkg::sts_t  sts
);

	localparam int BW  = (MAX_INPUT_BYTES > 1) ? $clog2(MAX_INPUT_BYTES) : 1;
	localparam int BCW = $clog2(MAX_INPUT_BYTES + 1);
	localparam int DCW = $clog2(MAX_INPUT_BYTES + 2);
	localparam logic [DCW-1:0] DC_MAX  = DCW'(MAX_INPUT_BYTES);
	localparam logic [DCW-1:0] DC_OVER = DCW'(MAX_INPUT_BYTES + 1);

	// Configuration
	logic [6:0]     node_q;
	logic [3:0]     ibc_q;
	logic [7:0]     addr;

	// Parser state
	logic           esc_q;
	logic [DCW-1:0] dcount_q;
	logic [2:0]     tx_pos_q;
	prr_pkg::err_t  err_q;
	logic [7:0]     cur_q [MAX_INPUT_BYTES];
	logic [7:0]     inc_q [MAX_INPUT_BYTES];

	// Change scan
	logic [BCW-1:0] sbyte_q;
	logic [2:0]     sbit_q;
	logic [BW-1:0]  sidx;
	logic           new_bit;
	logic           pend_valid_q;
	logic [5:0]     pend_idx_q;
	logic           pend_val_q;

	// Output register
	logic           out_valid_q;
	prr_pkg::kind_t kind_q;
	logic [7:0]     tx_q;
	logic [5:0]     idx_q;
	logic           val_q;
	prr_pkg::err_t  oerr_q;
	logic           last_q;
	logic           out_free;

	assign addr     = prr_pkg::ADDR_BASE + {1'b0, node_q};
	assign sidx     = sbyte_q[BW-1:0];
	assign new_bit  = inc_q[sidx][3'd7 - sbit_q];
	assign out_free = !out_valid_q || m_tready;

	// Status toward the controller
	always_comb begin
		sts.op         = s_tuser[0];
		sts.rx_err     = s_tuser[1];
		sts.is_pre     = (s_tdata == prr_pkg::BYTE_PRE);
		sts.is_stx     = (s_tdata == prr_pkg::BYTE_STX);
		sts.is_addr    = (s_tdata == addr);
		sts.is_get     = (s_tdata == prr_pkg::BYTE_GET);
		sts.is_esc     = (s_tdata == prr_pkg::BYTE_ESC);
		sts.is_etx     = (s_tdata == prr_pkg::BYTE_ETX);
		sts.esc        = esc_q;
		sts.len_ok     = (dcount_q <= DC_MAX) && (4'(dcount_q) == ibc_q);
		sts.tx_end     = (tx_pos_q == prr_pkg::TX_LAST_POS);
		sts.scan_end   = (4'(sbyte_q) >= 4'(dcount_q));
		sts.diff       = cur_q[sidx][3'd7 - sbit_q] ^ new_bit;
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
			ibc_q  <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				prr_pkg::CFG_NODE_NUMBER: node_q <= cfg_data;
				prr_pkg::CFG_BYTE_COUNT:  ibc_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q    <= 1'b0;
			dcount_q <= '0;
			tx_pos_q <= '0;
			err_q    <= prr_pkg::ERR_NONE;
		end else begin
			if (cmd.poll_start || cmd.esc_clr) begin
				esc_q <= 1'b0;
			end else if (cmd.esc_set) begin
				esc_q <= 1'b1;
			end
			if (cmd.poll_start) begin
				dcount_q <= '0;
			end else if (cmd.store) begin
				// saturate one past the buffer to flag overflow
				dcount_q <= (dcount_q < DC_MAX) ? dcount_q + 1'b1 : DC_OVER;
			end
			if (cmd.poll_start) begin
				tx_pos_q <= '0;
			end else if (cmd.tx_adv) begin
				tx_pos_q <= tx_pos_q + 1'b1;
			end
			if (cmd.err_set) begin
				err_q <= cmd.err_code;
			end
		end
	end

	// Incoming data buffer, meaningful only once written in this frame
	always_ff @(posedge clk) begin
		if (cmd.store && (dcount_q < DC_MAX)) begin
			inc_q[dcount_q[BW-1:0]] <= s_tdata;
		end
	end

	// Stored inputs, updated byte by byte as the scan passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_INPUT_BYTES; i++) begin
				cur_q[i] <= '0;
			end
		end else if (cmd.scan_adv && (sbit_q == 3'd7)) begin
			cur_q[sidx] <= inc_q[sidx];
		end
	end

	// Scan position and held-back change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbyte_q      <= '0;
			sbit_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.scan_start) begin
			sbyte_q      <= '0;
			sbit_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_adv) begin
				sbit_q <= sbit_q + 1'b1;
				if (sbit_q == 3'd7) begin
					sbyte_q <= sbyte_q + 1'b1;
				end
			end
			if (cmd.pend_take) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_take) begin
			pend_idx_q <= 6'({sidx, sbit_q});
			pend_val_q <= new_bit;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tx_q   <= '0;
			idx_q  <= '0;
			val_q  <= 1'b0;
			oerr_q <= prr_pkg::ERR_NONE;
			last_q <= 1'b1;
			case (cmd.out_sel)
				prr_pkg::OSEL_TX: begin
					kind_q <= prr_pkg::KIND_TX;
					tx_q   <= prr_pkg::frame_byte(tx_pos_q, addr);
					last_q <= (tx_pos_q == prr_pkg::TX_LAST_POS);
				end
				prr_pkg::OSEL_ERR: begin
					kind_q <= prr_pkg::KIND_ERROR;
					oerr_q <= err_q;
				end
				prr_pkg::OSEL_PEND: begin
					kind_q <= prr_pkg::KIND_CHANGE;
					idx_q  <= pend_idx_q;
					val_q  <= pend_val_q;
					last_q <= 1'b0;
				end
				prr_pkg::OSEL_PEND_LAST: begin
					kind_q <= prr_pkg::KIND_CHANGE;
					idx_q  <= pend_idx_q;
					val_q  <= pend_val_q;
				end
				default: begin
					kind_q <= prr_pkg::KIND_DONE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, oerr_q, val_q, idx_q, tx_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

### design/prr_checker.sv
module prr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Error and done results stand alone
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == prr_pkg::KIND_ERROR
		|| m_axis_tuser == prr_pkg::KIND_DONE) |-> m_axis_tlast)
		else $error("error or done result without last");

	// An error result carries a code and nothing else
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == prr_pkg::KIND_ERROR |->
		m_axis_tdata[17:15] != 3'd0 && m_axis_tdata[14:0] == 15'd0)
		else $error("malformed error result");

	// No new request while a burst is still being sent
	a_burst_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast && (m_axis_tuser == prr_pkg::KIND_TX
		|| m_axis_tuser == prr_pkg::KIND_CHANGE) |-> !s_axis_tready)
		else $error("input accepted in the middle of a result burst");

endmodule

bind poll_response_receiver_core prr_checker u_prr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

### dv/poll_response_receiver_core_tb.sv
`timescale 1ns / 100ps

module poll_response_receiver_core_tb;

	localparam int MAX_BYTES   = 8;
	localparam int SETTLE      = 24;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic [7:0] byte_q_t[$];

	typedef enum {
		RX_IDLE,
		RX_PRE,
		RX_ADDR,
		RX_CMD,
		RX_DATA
	} rx_phase_t;

	typedef struct {
		prr_pkg::kind_t kind;
		logic [7:0]     tx_byte;
		logic [5:0]     bit_index;
		logic           bit_value;
		prr_pkg::err_t  code;
		logic           last;
	} poll_result_t;

	// Tracks the poll parser and the stored input image, holds the results still owed
	class poll_tracker;
		rx_phase_t    phase;
		logic [6:0]   node;
		logic [3:0]   byte_count;
		logic         esc_pending;
		int           stored;
		logic [7:0]   inputs[MAX_BYTES];
		logic [7:0]   incoming[MAX_BYTES];
		poll_result_t due[$];
		int           errors;

		function new();
			phase       = RX_IDLE;
			node        = '0;
			byte_count  = 4'd8;
			esc_pending = 1'b0;
			stored      = 0;
			errors      = 0;
			foreach (inputs[i]) begin
				inputs[i]   = '0;
				incoming[i] = '0;
			end
		endfunction

		function void set_reg(logic idx, logic [6:0] data);
			if (idx == prr_pkg::CFG_NODE_NUMBER) begin
				node = data;
			end else begin
				byte_count = data[3:0];
			end
		endfunction

		function void queue_result(prr_pkg::kind_t kind, logic [7:0] tx, logic [5:0] idx,
		                           logic val, prr_pkg::err_t code, logic last);
			poll_result_t r;
			r.kind      = kind;
			r.tx_byte   = tx;
			r.bit_index = idx;
			r.bit_value = val;
			r.code      = code;
			r.last      = last;
			due.push_back(r);
		endfunction

		// Drop the frame and owe a single error result
		function void abort_frame(prr_pkg::err_t code);
			phase       = RX_IDLE;
			esc_pending = 1'b0;
			queue_result(prr_pkg::KIND_ERROR, '0, '0, 1'b0, code, 1'b1);
		endfunction

		// Keep a data byte; overflow saturates one past the buffer
		function void keep_byte(logic [7:0] b);
			if (stored < MAX_BYTES) begin
				incoming[stored] = b;
				stored++;
			end else begin
				stored = MAX_BYTES + 1;
			end
		endfunction

		// End of frame: length check, then report changed bits MSB first
		function void close_frame();
			int changes;
			changes = 0;
			if (stored > MAX_BYTES || stored != int'(byte_count)) begin
				abort_frame(prr_pkg::ERR_LENGTH);
				return;
			end
			phase       = RX_IDLE;
			esc_pending = 1'b0;
			for (int i = 0; i < stored; i++) begin
				for (int b = 0; b < 8; b++) begin
					if (inputs[i][7-b] != incoming[i][7-b]) begin
						queue_result(prr_pkg::KIND_CHANGE, '0, 6'(i * 8 + b),
						             incoming[i][7-b], prr_pkg::ERR_NONE, 1'b0);
						changes++;
					end
				end
				inputs[i] = incoming[i];
			end
			if (changes == 0) begin
				queue_result(prr_pkg::KIND_DONE, '0, '0, 1'b0, prr_pkg::ERR_NONE, 1'b1);
			end else begin
				due[$].last = 1'b1;
			end
		endfunction

		// Advance the parser by one accepted request
		function void take_request(logic op, logic [7:0] b, logic rx_err);
			logic [7:0] addr;
			addr = prr_pkg::ADDR_BASE + {1'b0, node};
			if (!op) begin
				queue_result(prr_pkg::KIND_TX, prr_pkg::BYTE_PRE, '0, 1'b0,
				             prr_pkg::ERR_NONE, 1'b0);
				queue_result(prr_pkg::KIND_TX, prr_pkg::BYTE_PRE, '0, 1'b0,
				             prr_pkg::ERR_NONE, 1'b0);
				queue_result(prr_pkg::KIND_TX, prr_pkg::BYTE_STX, '0, 1'b0,
				             prr_pkg::ERR_NONE, 1'b0);
				queue_result(prr_pkg::KIND_TX, addr, '0, 1'b0, prr_pkg::ERR_NONE, 1'b0);
				queue_result(prr_pkg::KIND_TX, prr_pkg::BYTE_POLL, '0, 1'b0,
				             prr_pkg::ERR_NONE, 1'b0);
				queue_result(prr_pkg::KIND_TX, prr_pkg::BYTE_ETX, '0, 1'b0,
				             prr_pkg::ERR_NONE, 1'b1);
				phase       = RX_PRE;
				esc_pending = 1'b0;
				stored      = 0;
				return;
			end
			if (phase == RX_IDLE)
				return;
			if (rx_err) begin
				abort_frame(prr_pkg::ERR_READ);
				return;
			end
			case (phase)
				RX_PRE: begin
					if (b == prr_pkg::BYTE_STX)
						phase = RX_ADDR;
					else if (b != prr_pkg::BYTE_PRE)
						abort_frame(prr_pkg::ERR_NO_STX);
				end
				RX_ADDR: begin
					if (b == addr)
						phase = RX_CMD;
					else
						abort_frame(prr_pkg::ERR_ADDRESS);
				end
				RX_CMD: begin
					if (b == prr_pkg::BYTE_GET)
						phase = RX_DATA;
					else
						abort_frame(prr_pkg::ERR_COMMAND);
				end
				default: begin
					if (esc_pending) begin
						esc_pending = 1'b0;
						keep_byte(b);
					end else if (b == prr_pkg::BYTE_ESC) begin
						esc_pending = 1'b1;
					end else if (b == prr_pkg::BYTE_ETX) begin
						close_frame();
					end else begin
						keep_byte(b);
					end
				end
			endcase
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare one accepted result against the oldest one owed
		function void check_response(logic [1:0] kind, logic [7:0] tx, logic [5:0] idx,
		                             logic val, logic [2:0] code, logic last);
			poll_result_t r;
			if (due.size() == 0) begin
				$display("%0t: unexpected result: expected none actual kind %0d tx %0d idx %0d",
				         $time, kind, tx, idx);
				errors++;
				return;
			end
			r = due.pop_front();
			compare_field("kind", int'(r.kind), int'(kind));
			compare_field("tx_byte", int'(r.tx_byte), int'(tx));
			compare_field("bit_index", int'(r.bit_index), int'(idx));
			compare_field("bit_value", int'(r.bit_value), int'(val));
			compare_field("error_code", int'(r.code), int'(code));
			compare_field("last", int'(r.last), int'(last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [6:0]  cfg_data = '0;

	poll_tracker tracker = new();
	logic        bursts_on = 1'b1;
	int          stall_left = 0;
	int          requests_sent = 0;
	int          cycles = 0;
	logic [6:0]  node_sel = '0;
	logic [3:0]  count_sel = 4'd8;

	poll_response_receiver_core #(
		.MAX_INPUT_BYTES(MAX_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("poll_response_receiver_core_tb failed");
			$finish;
		end
	end

	// Sink: stall in short random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (bursts_on && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Observe both streams at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_request(s_axis_tuser[0], s_axis_tdata, s_axis_tuser[1]);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_response(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8],
				                       m_axis_tdata[14], m_axis_tdata[17:15], m_axis_tlast);
		end
	end

	// Offer one request, with an optional idle burst ahead of it; valid stays high
	task automatic send_request(input logic op, input logic [7:0] b, input logic rx_err);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= {rx_err, op};
		do @(posedge clk); while (!s_axis_tready);
		requests_sent++;
	endtask

	task automatic send_bytes(input byte_q_t seq);
		foreach (seq[i])
			send_request(1'b1, seq[i], 1'b0);
	endtask

	// Wait for every owed result, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		// wait so the last accepted request is already noted
		@(posedge clk);
		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic configure(input logic [6:0] node, input logic [3:0] count);
		cfg_valid <= 1'b1;
		cfg_index <= prr_pkg::CFG_NODE_NUMBER;
		cfg_data  <= node;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(prr_pkg::CFG_NODE_NUMBER, node);
		cfg_index <= prr_pkg::CFG_BYTE_COUNT;
		cfg_data  <= {3'b000, count};
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(prr_pkg::CFG_BYTE_COUNT, {3'b000, count});
		cfg_valid <= 1'b0;
		node_sel  = node;
		count_sel = count;
	endtask

	// One poll and its response, mostly well formed, sometimes broken
	task automatic send_frame();
		byte_q_t    wire_q;
		int         n;
		int         mode;
		int         spot;
		logic [7:0] d;
		mode = $urandom_range(0, 9);
		n = (count_sel > MAX_BYTES || $urandom_range(0, 4) == 0) ? $urandom_range(0, 10)
		                                                         : int'(count_sel);
		repeat ($urandom_range(0, 2)) wire_q.push_back(prr_pkg::BYTE_PRE);
		wire_q.push_back(prr_pkg::BYTE_STX);
		wire_q.push_back(prr_pkg::ADDR_BASE + {1'b0, node_sel});
		wire_q.push_back(prr_pkg::BYTE_GET);
		repeat (n) begin
			d = 8'($urandom);
			if (d == prr_pkg::BYTE_ESC || d == prr_pkg::BYTE_ETX || $urandom_range(0, 7) == 0)
				wire_q.push_back(prr_pkg::BYTE_ESC);
			wire_q.push_back(d);
		end
		wire_q.push_back(prr_pkg::BYTE_ETX);
		spot = $urandom_range(0, wire_q.size() - 1);
		if (mode == 6)
			wire_q[spot] = 8'($urandom);

		send_request(1'b0, 8'($urandom), 1'($urandom));
		foreach (wire_q[k]) begin
			if (mode == 9 && k == spot)
				send_request(1'b0, 8'($urandom), 1'($urandom));
			send_request(1'b1, wire_q[k], mode == 7 && k == spot);
			if (mode == 8 && k == spot)
				break;
		end
		// line noise between polls
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2))
				send_request(1'b1, 8'($urandom), 1'($urandom));
	endtask

	initial begin
		int start;
		logic [6:0] node;
		logic [3:0] count;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: bytes while idle, then a full eight-byte frame with escapes
		send_request(1'b1, 8'h00, 1'b1);
		send_request(1'b1, 8'hFF, 1'b0);
		send_request(1'b0, 8'hA5, 1'b1);
		send_bytes('{prr_pkg::BYTE_PRE, prr_pkg::BYTE_STX, prr_pkg::ADDR_BASE,
		             prr_pkg::BYTE_GET, 8'hFF, 8'h00, prr_pkg::BYTE_ESC,
		             prr_pkg::BYTE_ESC, prr_pkg::BYTE_ESC, prr_pkg::BYTE_ETX,
		             8'h80, 8'h01, 8'hAA, 8'h55, prr_pkg::BYTE_ETX});
		drain();

		// Highest node, one byte: abandoned poll and each header error
		configure(7'd127, 4'd1);
		send_request(1'b0, 8'h00, 1'b0);
		send_request(1'b0, 8'hFF, 1'b0);
		send_bytes('{8'h55});
		send_request(1'b0, 8'h00, 1'b0);
		send_bytes('{prr_pkg::BYTE_STX, 8'h41});
		send_request(1'b0, 8'h00, 1'b0);
		send_bytes('{prr_pkg::BYTE_STX, 8'd192, prr_pkg::BYTE_POLL});
		send_request(1'b0, 8'h00, 1'b0);
		send_bytes('{prr_pkg::BYTE_STX, 8'd192, prr_pkg::BYTE_GET, prr_pkg::BYTE_ESC});
		send_request(1'b1, 8'h33, 1'b1);
		drain();

		// Random frames over several settings; the last one runs without idling
		for (int p = 0; p < 6; p++) begin
			node = 7'($urandom);
			case (p)
				0: count = 4'd8;
				1: begin
					node  = 7'd0;
					count = 4'd1;
				end
				2: count = 4'd0;
				3: count = 4'($urandom_range(MAX_BYTES + 1, 15));
				4: count = 4'($urandom_range(1, MAX_BYTES));
				default: begin
					node      = 7'd127;
					count     = 4'($urandom_range(1, MAX_BYTES));
					bursts_on = 1'b0;
				end
			endcase
			configure(node, count);
			start = requests_sent;
			while (requests_sent - start < 10)
				send_frame();
			drain();
		end

		if (tracker.errors == 0 && tracker.due.size() == 0) begin
			$display("poll_response_receiver_core_tb passed");
		end else begin
			$display("poll_response_receiver_core_tb failed");
		end
		$finish;
	end

endmodule

### filelist.f
design/prr_pkg.sv
design/prr_ctrl.sv
design/prr_datapath.sv
design/poll_response_receiver_core.sv
design/prr_checker.sv
dv/poll_response_receiver_core_tb.sv
